// ----- src/mh64_pkg.sv -----
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared constants, types and helpers for the 64-bit string hash core.
// ----------------------------------------------------------------------------
package mh64_pkg;

  localparam int unsigned HashW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned LenW   = 32;
  localparam int unsigned CountW = 4;

  localparam logic [HalfW-1:0]  MulLo     = 32'h5bd1e995;
  localparam logic [HalfW-1:0]  MulHi     = 32'hc6a4a793;
  localparam logic [HashW-1:0]  SeedReset = 64'h0000_0000_c70f_6907;
  localparam int unsigned       MixShift  = 47;
  localparam logic [CountW-1:0] FullCount = 4'd8;
  localparam logic [CountW-1:0] ZeroCount = 4'd0;

  // Sequencer state
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISP,
    ST_MUL
  } state_e;

  // What to do with the product once the multiply finishes
  typedef enum logic [2:0] {
    PH_SEED,
    PH_PRE1,
    PH_PRE2,
    PH_HASH,
    PH_FIN
  } phase_e;

  typedef logic [1:0] step_t;

  localparam step_t StepLo   = 2'd0;
  localparam step_t StepHiLo = 2'd1;
  localparam step_t StepLoHi = 2'd2;

  function automatic logic [HashW-1:0] xorshift(input logic [HashW-1:0] v);
    xorshift = v ^ (v >> MixShift);
  endfunction

  // Keep the low count bytes of a word
  function automatic logic [HashW-1:0] byte_keep(input logic [CountW-1:0] cnt);
    logic [HashW-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (CountW'(i) < cnt) begin
        m[8*i +: 8] = 8'hff;
      end
    end
    byte_keep = m;
  endfunction

endpackage

// ----- src/mh64_in_if.sv -----
// ----------------------------------------------------------------------------
// mh64_in_if
// Input word channel: valid/ready handshake with the string word payload.
// ----------------------------------------------------------------------------
interface mh64_in_if;
  logic                         valid;
  logic                         ready;
  logic [mh64_pkg::LenW-1:0]    total_length;
  logic [mh64_pkg::HashW-1:0]   data_word;
  logic [mh64_pkg::CountW-1:0]  byte_count;
  logic                         first_word;
  logic                         last_word;

  modport source (
    output valid, total_length, data_word, byte_count, first_word, last_word,
    input  ready
  );
  modport sink (
    input  valid, total_length, data_word, byte_count, first_word, last_word,
    output ready
  );
endinterface

// ----- src/mh64_out_if.sv -----
// ----------------------------------------------------------------------------
// mh64_out_if
// Result channel: valid/ready handshake carrying the finished hash.
// ----------------------------------------------------------------------------
interface mh64_out_if;
  logic                        valid;
  logic                        ready;
  logic [mh64_pkg::HashW-1:0]  hash_value;

  modport source (
    output valid, hash_value,
    input  ready
  );
  modport sink (
    input  valid, hash_value,
    output ready
  );
endinterface

// ----- src/murmur64_string_hash_core.sv -----
// ----------------------------------------------------------------------------
// murmur64_string_hash_core
// 64-bit multiply/xorshift string hash over little-endian 8-byte words.
// ----------------------------------------------------------------------------
// A string arrives as a run of words on word_i; the first carries the total
// length, the last closes the string and yields one hash on hash_o. All
// arithmetic runs through one 32x32 multiplier; a 64-bit product by the
// constant multiplier is built from partial products in turn (low x low,
// high x low, low x high). The core takes one word at a time and drops
// ready while it works: a middle full word runs accept, dispatch and three
// products, a partial word one product, a zero-byte word no product; the
// first word adds the seed product and the last adds the final product. A
// finished hash waits in an output register; if it is still unclaimed when
// the next one completes, the core holds there until hash_o takes it. Write
// the seed only while idle; it applies from the next first word.
// ----------------------------------------------------------------------------
module murmur64_string_hash_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mh64_pkg::HashW-1:0]  cfg_wdata_i,
  mh64_in_if.sink                     word_i,
  mh64_out_if.source                  hash_o
);
  import mh64_pkg::*;

  // Length mask for the seed product
  localparam logic [HashW-1:0] LenMask =
    (LENGTH_BITS >= 64) ? {HashW{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);

  state_e            state_q, state_d;
  step_t             step_q, step_d;
  phase_e            ph_q, ph_d;
  logic              in_msg_q, in_msg_d;
  logic              out_valid_q, out_valid_d;
  logic [HashW-1:0]  seed_q;
  logic [HashW-1:0]  hash_q, hash_d;
  logic [HashW-1:0]  mop_q, mop_d;
  logic [HashW-1:0]  acc_q, acc_d;
  logic [HashW-1:0]  out_q, out_d;
  logic [HashW-1:0]  word_q, word_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              last_q, last_d;

  logic              accept;
  logic              out_free;
  logic              mul_done;
  logic              fin_stall;
  logic [CountW-1:0] cnt_in;
  logic [HalfW-1:0]  a_half, b_half;
  logic [HashW-1:0]  prod;
  logic [HashW-1:0]  res;

  assign word_i.ready      = (state_q == ST_IDLE);
  assign accept            = word_i.valid && word_i.ready;
  assign hash_o.valid      = out_valid_q;
  assign hash_o.hash_value = out_q;
  assign out_free          = !out_valid_q || hash_o.ready;

  // Clamp oversized byte counts to a full word
  assign cnt_in = (word_i.byte_count > FullCount) ? FullCount : word_i.byte_count;

  // Shared multiplier: one 32x32 partial product per cycle unless stalled
  assign a_half = (step_q == StepHiLo) ? mop_q[HashW-1:HalfW] : mop_q[HalfW-1:0];
  assign b_half = (step_q == StepLoHi) ? MulHi : MulLo;
  assign prod   = HashW'(a_half) * HashW'(b_half);

  // Fold the partial product in; only the low 32 bits of cross terms count
  always_comb begin
    if (step_q == StepLo) begin
      res = prod;
    end else begin
      res = {acc_q[HashW-1:HalfW] + prod[HalfW-1:0], acc_q[HalfW-1:0]};
    end
  end

  assign mul_done  = (state_q == ST_MUL) && (step_q == StepLoHi);
  // Hold the final product until the output register is free
  assign fin_stall = mul_done && (ph_q == PH_FIN) && !out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = StepLo;
        if (accept) begin
          if (word_i.first_word) begin
            state_d = ST_MUL;
          end else if (in_msg_q) begin
            state_d = ST_DISP;
          end
        end
      end
      ST_DISP: begin
        step_d  = StepLo;
        state_d = ((cnt_q != ZeroCount) || last_q) ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        if (!mul_done) begin
          step_d = step_q + 2'd1;
        end else if (!fin_stall) begin
          step_d = StepLo;
          unique case (ph_q) inside
            PH_SEED:          state_d = ST_DISP;
            PH_PRE1, PH_PRE2: state_d = ST_MUL;
            PH_HASH:          state_d = last_q ? ST_MUL : ST_IDLE;
            PH_FIN:           state_d = ST_IDLE;
            default:          state_d = ST_IDLE;
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = StepLo;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    ph_d        = ph_q;
    in_msg_d    = in_msg_q;
    out_valid_d = out_valid_q;
    hash_d      = hash_q;
    mop_d       = mop_q;
    acc_d       = acc_q;
    out_d       = out_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    last_d      = last_q;

    if (out_valid_q && hash_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          word_d = word_i.data_word;
          cnt_d  = cnt_in;
          last_d = word_i.last_word;
          if (word_i.first_word) begin
            // Restart: any open string is dropped
            in_msg_d = 1'b1;
            mop_d    = {HashW'(word_i.total_length)} & LenMask;
            ph_d     = PH_SEED;
          end
        end
      end
      ST_DISP: begin
        if (cnt_q == FullCount) begin
          mop_d = word_q;
          ph_d  = PH_PRE1;
        end else if (cnt_q != ZeroCount) begin
          mop_d = hash_q ^ (word_q & byte_keep(cnt_q));
          ph_d  = PH_HASH;
        end else begin
          mop_d = xorshift(hash_q);
          ph_d  = PH_FIN;
        end
      end
      ST_MUL: begin
        if (!fin_stall) begin
          acc_d = res;
        end
        if (mul_done && !fin_stall) begin
          unique case (ph_q)
            PH_SEED: begin
              hash_d = seed_q ^ res;
            end
            PH_PRE1: begin
              mop_d = xorshift(res);
              ph_d  = PH_PRE2;
            end
            PH_PRE2: begin
              mop_d = hash_q ^ res;
              ph_d  = PH_HASH;
            end
            PH_HASH: begin
              hash_d = res;
              mop_d  = xorshift(res);
              ph_d   = PH_FIN;
            end
            PH_FIN: begin
              out_d       = xorshift(res);
              out_valid_d = 1'b1;
              in_msg_d    = 1'b0;
            end
            default: begin
              ph_d = PH_FIN;
            end
          endcase
        end
      end
      default: begin
        ph_d = ph_q;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= StepLo;
      ph_q        <= PH_SEED;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
      seed_q      <= SeedReset;
      hash_q      <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ph_q        <= ph_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
      hash_q      <= hash_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mop_q  <= mop_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
    word_q <= word_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
  end

  // A new hash only appears as the open string closes
  a_out_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $fell(in_msg_q))
    else $error("hash emitted without closing a string");

  // A first word starts the seed product at its low partial
  a_first_seeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && word_i.first_word) |=>
      (state_q == ST_MUL && ph_q == PH_SEED && step_q == StepLo))
    else $error("first word did not start the seed product");

  // Partial-product steps advance only inside a multiply
  a_step_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != StepLo) |-> (state_q == ST_MUL && step_q != 2'd3))
    else $error("multiplier step outside a multiply");

endmodule

// ----- tb/sv/murmur64_string_hash_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// murmur64_string_hash_core_test
// Self-checking bench for the 64-bit string hash core: drives strings of
// little-endian words, predicts each finished hash and compares it with the
// delivered hash, across seed settings and idle/stall mixes on both channels.
// ----------------------------------------------------------------------------
module murmur64_string_hash_core_test;

  import mh64_pkg::*;

  // Hash multiplier assembled from the package halves
  localparam logic [HashW-1:0] HashMul     = {MulHi, MulLo};
  // Pause before a seed write: covers the slowest word plus the final product
  localparam int unsigned      SettleCycles = 40;
  localparam int unsigned      PhaseWords   = 325;
  localparam int unsigned      CycleLimit   = 600000;

  typedef struct packed {
    logic [LenW-1:0]   total_length;
    logic [HashW-1:0]  data_word;
    logic [CountW-1:0] byte_count;
    logic              first_word;
    logic              last_word;
  } word_t;

  typedef enum bit {ROW_WORD, ROW_SEED} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    word_t            w;
    logic [HashW-1:0] value;   // seed for seed rows, known hash for typed rows
    bit               typed;
  } row_t;

  typedef enum int {BRK_OPEN, BRK_SHORT, BRK_HEADLESS} break_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [HashW-1:0] cfg_wdata_i;

  mh64_in_if  word_if ();
  mh64_out_if hash_if ();

  murmur64_string_hash_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_i      (word_if),
    .hash_o      (hash_if)
  );

  // Predictor state: its own seed, running hash and open-string flag
  logic [HashW-1:0] hash_seed;
  logic [HashW-1:0] run_hash;
  bit               str_open;
  logic [HashW-1:0] pending_hashes[$];

  // A typed row hands its known hash to the predictor through these
  bit               typed_valid;
  logic [HashW-1:0] typed_hash;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned words_sent;
  int unsigned cycle_cnt;
  int          errors;

  row_t dir_rows[$];

  // --------------------------------------------------------------------------
  // Clock, cycle counter and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Abort a hung run; the limit sits far above the slowest correct run
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("murmur64_string_hash_core_test: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [HashW-1:0] fold47(input logic [HashW-1:0] v);
    return v ^ (v >> MixShift);
  endfunction

  // Fold one accepted word into the running hash; queue a hash on the last word
  task automatic absorb_word(input word_t w);
    logic [CountW-1:0] cnt;
    logic [HashW-1:0]  keep;
    logic [HashW-1:0]  fin;
    cnt = (w.byte_count > FullCount) ? FullCount : w.byte_count;
    if (w.first_word) begin
      // Open (or restart) a string: seed mixed with the length
      run_hash = hash_seed ^ (HashW'(w.total_length) * HashMul);
      str_open = 1'b1;
    end else if (!str_open) begin
      return;  // stray word outside a string: drop it
    end
    if (cnt == FullCount) begin
      run_hash = run_hash ^ (fold47(w.data_word * HashMul) * HashMul);
      run_hash = run_hash * HashMul;
    end else if (cnt != ZeroCount) begin
      // Partial word goes in raw, bytes above the count cleared
      keep     = (64'd1 << (8 * int'(cnt))) - 64'd1;
      run_hash = (run_hash ^ (w.data_word & keep)) * HashMul;
    end
    if (!w.last_word) return;
    fin = fold47(fold47(run_hash) * HashMul);
    pending_hashes.push_back(typed_valid ? typed_hash : fin);
    str_open = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [HashW-1:0] got,
                                 input logic [HashW-1:0] want);
    errors++;
    $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample both channels and the seed port at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (word_if.valid === 1'b1 && word_if.ready === 1'b1) begin
        absorb_word('{word_if.total_length, word_if.data_word, word_if.byte_count,
                      word_if.first_word, word_if.last_word});
      end
      if (hash_if.valid === 1'b1 && hash_if.ready === 1'b1) begin
        if (pending_hashes.size() == 0) begin
          report_mismatch("hash with none pending", hash_if.hash_value, '0);
        end else if (hash_if.hash_value !== pending_hashes[0]) begin
          report_mismatch("hash_value", hash_if.hash_value, pending_hashes[0]);
          void'(pending_hashes.pop_front());
        end else begin
          void'(pending_hashes.pop_front());
        end
      end
      // Seed lands at this edge and applies from the next first word
      if (cfg_we_i) begin
        hash_seed = cfg_wdata_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: stall at the phase's rate
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    hash_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic row_t word_row(input logic [LenW-1:0] len,
                                    input logic [HashW-1:0] data,
                                    input logic [CountW-1:0] cnt,
                                    input bit first, input bit last,
                                    input bit typed = 1'b0,
                                    input logic [HashW-1:0] hash = '0);
    row_t r;
    r.kind  = ROW_WORD;
    r.w     = '{len, data, cnt, first, last};
    r.value = hash;
    r.typed = typed;
    return r;
  endfunction

  function automatic row_t seed_row(input logic [HashW-1:0] seed);
    row_t r;
    r.kind  = ROW_SEED;
    r.w     = '0;
    r.value = seed;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic word_t noise_word();
    word_t w;
    w.total_length = $urandom();
    w.data_word    = {$urandom(), $urandom()};
    w.byte_count   = CountW'($urandom_range(15));
    w.first_word   = 1'($urandom_range(1));
    w.last_word    = 1'($urandom_range(1));
    return w;
  endfunction

  // Present one word after a random gap and hold it until the core takes it
  task automatic send_word(input word_t w);
    while ($urandom_range(99) < idle_pct) begin
      word_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    word_if.valid        <= 1'b1;
    word_if.total_length <= w.total_length;
    word_if.data_word    <= w.data_word;
    word_if.byte_count   <= w.byte_count;
    word_if.first_word   <= w.first_word;
    word_if.last_word    <= w.last_word;
    @(posedge clk_i);
    while (word_if.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Drain, let the core settle, then pulse the seed write for one cycle
  task automatic write_seed(input logic [HashW-1:0] seed);
    word_if.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed strings with random content; some broken, some noise
  task automatic send_random_string();
    word_t       words[$];
    word_t       w;
    int unsigned pick;
    int unsigned nw;
    int unsigned tail;
    int unsigned k;
    break_e      mode;
    pick = $urandom_range(99);
    if (pick >= 90) begin
      send_word(noise_word());
      return;
    end
    // Keep most strings short; a few run long
    nw   = ($urandom_range(9) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 1);
    tail = (nw == 1) ? $urandom_range(8, 0) : $urandom_range(8, 1);
    for (k = 0; k < nw; k++) begin
      w.total_length = '0;
      w.data_word    = {$urandom(), $urandom()};
      w.byte_count   = (k == nw - 1) ? CountW'(tail) : FullCount;
      w.first_word   = (k == 0);
      w.last_word    = (k == nw - 1);
      words.push_back(w);
    end
    words[0].total_length = ($urandom_range(7) == 0) ? LenW'($urandom())
                                                     : LenW'(8 * (nw - 1) + tail);
    if (pick >= 80) begin
      mode = break_e'($urandom_range(2));
      k    = $urandom_range(nw - 1);
      case (mode)
        BRK_OPEN:     words[nw-1].last_word = 1'b0;   // leave it open
        BRK_SHORT:    words[k].byte_count = CountW'($urandom_range(15));
        BRK_HEADLESS: words[0].first_word = 1'b0;     // no first word: dropped unless a string is open
        default: ;
      endcase
    end
    foreach (words[i]) send_word(words[i]);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [HashW-1:0] phase_seed[4];
    int unsigned      phase_idle[4];
    int unsigned      phase_stall[4];
    int unsigned      phase_end;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    word_if.valid        = 1'b0;
    word_if.total_length = '0;
    word_if.data_word    = '0;
    word_if.byte_count   = '0;
    word_if.first_word   = 1'b0;
    word_if.last_word    = 1'b0;
    hash_if.ready        = 1'b0;
    hash_seed            = SeedReset;
    run_hash             = '0;
    str_open             = 1'b0;
    typed_valid          = 1'b0;
    typed_hash           = '0;
    cycle_cnt            = 0;
    words_sent           = 0;
    errors               = 0;
    idle_pct             = 25;
    stall_pct            = 25;

    // Phase plan: seed and idle/stall mix per phase, extremes of the seed included
    phase_seed  = '{SeedReset, '0, '1, {$urandom(), $urandom()}};
    phase_idle  = '{0, 84, 0, 38};
    phase_stall = '{0, 0, 84, 38};

    // Directed table. Typed hashes are the zero-seed, zero-length cases where
    // every term vanishes; everything else goes through the predictor.
    dir_rows.push_back(word_row(32'd8, '1, FullCount, 1'b0, 1'b1));     // stray word
    dir_rows.push_back(word_row('0, 64'h0123_4567_89ab_cdef, ZeroCount, 1'b1, 1'b1));
    dir_rows.push_back(word_row(32'd8, '1, FullCount, 1'b1, 1'b1));
    dir_rows.push_back(word_row('1, 64'hfedc_ba98_7654_3210, 4'hf, 1'b1, 1'b1)); // count > 8
    dir_rows.push_back(word_row(32'd15, 64'h1111_2222_3333_4444, FullCount, 1'b1, 1'b0));
    dir_rows.push_back(word_row('0, 64'h8877_6655_4433_2211, 4'd7, 1'b0, 1'b1));
    dir_rows.push_back(word_row(32'd11, 64'hdead_beef_cafe_f00d, 4'd3, 1'b1, 1'b0)); // short mid
    dir_rows.push_back(word_row('0, 64'h0f0f_0f0f_f0f0_f0f0, FullCount, 1'b0, 1'b1));
    dir_rows.push_back(word_row(32'd16, 64'h5555_aaaa_5555_aaaa, FullCount, 1'b1, 1'b0));
    dir_rows.push_back(word_row(32'd5, 64'h0000_00ab_cdef_0123, 4'd5, 1'b1, 1'b1)); // restart
    dir_rows.push_back(word_row(32'd9, 64'h0102_0304_0506_0708, FullCount, 1'b1, 1'b0));
    dir_rows.push_back(word_row('0, '1, ZeroCount, 1'b0, 1'b0));        // zero bytes mid
    dir_rows.push_back(word_row('0, 64'h0000_0000_0000_00c3, 4'd1, 1'b0, 1'b1));
    dir_rows.push_back(seed_row('0));
    dir_rows.push_back(word_row('0, '1, ZeroCount, 1'b1, 1'b1, 1'b1, '0));
    dir_rows.push_back(word_row('0, '0, FullCount, 1'b1, 1'b1, 1'b1, '0));
    dir_rows.push_back(word_row('0, 64'hffff_ffff_ff00_0000, 4'd3, 1'b1, 1'b1, 1'b1, '0));
    dir_rows.push_back(word_row('0, '0, 4'd9, 1'b1, 1'b1, 1'b1, '0));
    dir_rows.push_back(seed_row('1));
    dir_rows.push_back(word_row('1, '1, FullCount, 1'b1, 1'b1));
    dir_rows.push_back(word_row(32'd1, 64'h0000_0000_0000_0080, 4'd1, 1'b1, 1'b1));
    dir_rows.push_back(word_row(32'd12, 64'h7fff_ffff_ffff_fffe, 4'd12, 1'b1, 1'b1));
    dir_rows.push_back(word_row(32'd3, 64'h0000_0000_0012_3456, 4'd3, 1'b0, 1'b1)); // stray

    // Hold reset, then release it on a falling edge
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SEED) begin
        write_seed(dir_rows[i].value);
      end else begin
        typed_valid = dir_rows[i].typed;
        typed_hash  = dir_rows[i].value;
        send_word(dir_rows[i].w);
        typed_valid = 1'b0;
      end
    end

    // Random phases, each with its own seed and idle/stall mix
    for (int p = 0; p < 4; p++) begin
      write_seed(phase_seed[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      phase_end = words_sent + PhaseWords;
      while (words_sent < phase_end) send_random_string();
    end

    // Drain and let the core go quiet before judging
    word_if.valid <= 1'b0;
    stall_pct = 0;
    while (pending_hashes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (pending_hashes.size() != 0) begin
      report_mismatch("hashes never delivered", HashW'(pending_hashes.size()), '0);
    end

    if (errors == 0) begin
      $display("murmur64_string_hash_core_test: done, clean");
    end else begin
      $display("murmur64_string_hash_core_test: done, errors");
    end
    $finish;
  end

endmodule
